[design/fsa_pkg.sv]
`timescale 1ns / 1ps
package fsa_pkg;

   localparam int ACC_WIDTH        = 32;
   localparam int REM_WIDTH        = 24;
   localparam int QUO_WIDTH        = 16;
   localparam int CNT_WIDTH        = 4;
   localparam int PC_WIDTH         = 4;
   localparam int STEP_LEN_WIDTH   = 25;
   localparam int STEP_LIM_WIDTH   = 8;
   localparam int PROD_WIDTH       = STEP_LEN_WIDTH + STEP_LIM_WIDTH;
   localparam int DROP_TIME_WIDTH  = 48;
   localparam int COUNT_WIDTH      = 32;
   localparam int ELAPSED_WIDTH    = 32;
   localparam int BLEND_WIDTH      = 17;
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH   = 25;

   localparam logic [STEP_LEN_WIDTH-1:0] STEP_LENGTH_MIN   = 25'd65536;
   localparam logic [STEP_LEN_WIDTH-1:0] STEP_LENGTH_MAX   = 25'd16777216;
   localparam logic [STEP_LEN_WIDTH-1:0] STEP_LENGTH_RESET = 25'd279620;
   localparam logic [STEP_LIM_WIDTH-1:0] STEP_LIMIT_RESET  = 8'd5;
   localparam logic [STEP_LIM_WIDTH-1:0] STEP_LIMIT_MAX    = 8'd255;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_LIMIT  = 4'd1;

   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(QUO_WIDTH - 1);

   // Program addresses
   localparam logic [PC_WIDTH-1:0] PC_IDLE       = 4'd0;
   localparam logic [PC_WIDTH-1:0] PC_DIV_INIT   = 4'd1;
   localparam logic [PC_WIDTH-1:0] PC_DIV_STEP   = 4'd2;
   localparam logic [PC_WIDTH-1:0] PC_CLAMP      = 4'd3;
   localparam logic [PC_WIDTH-1:0] PC_LEFTOVER   = 4'd4;
   localparam logic [PC_WIDTH-1:0] PC_DROP       = 4'd5;
   localparam logic [PC_WIDTH-1:0] PC_CLEAR      = 4'd6;
   localparam logic [PC_WIDTH-1:0] PC_BLEND_INIT = 4'd7;
   localparam logic [PC_WIDTH-1:0] PC_BLEND_STEP = 4'd8;
   localparam logic [PC_WIDTH-1:0] PC_EMIT       = 4'd9;
   localparam logic [PC_WIDTH-1:0] PC_RETURN     = 4'd10;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_ACCEPT,
      ACT_DIV_INIT,
      ACT_DIV_STEP,
      ACT_CLAMP,
      ACT_LEFTOVER,
      ACT_DROP,
      ACT_CLEAR,
      ACT_BLEND_INIT,
      ACT_EMIT
   } action_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_OP_CLEAR,
      COND_CNT_NZ,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      action_type          action;
      cond_type            cond;
      logic [PC_WIDTH-1:0] target;
      logic                load_cnt;
   } word_type;

   typedef struct packed {
      logic req_valid;
      logic op_clear;
      logic out_busy;
   } status_type;

   typedef struct packed {
      action_type action;
   } ctrl_type;

   function automatic word_type fsa_rom(input logic [PC_WIDTH-1:0] addr);
      word_type w;
      begin
         unique case (addr)
            PC_IDLE:       w = '{ACT_ACCEPT,     COND_NO_REQ,   PC_IDLE,       1'b0};
            PC_DIV_INIT:   w = '{ACT_DIV_INIT,   COND_OP_CLEAR, PC_CLEAR,      1'b1};
            PC_DIV_STEP:   w = '{ACT_DIV_STEP,   COND_CNT_NZ,   PC_DIV_STEP,   1'b0};
            PC_CLAMP:      w = '{ACT_CLAMP,      COND_NEXT,     PC_IDLE,       1'b0};
            PC_LEFTOVER:   w = '{ACT_LEFTOVER,   COND_NEXT,     PC_IDLE,       1'b0};
            PC_DROP:       w = '{ACT_DROP,       COND_ALWAYS,   PC_BLEND_INIT, 1'b0};
            PC_CLEAR:      w = '{ACT_CLEAR,      COND_NEXT,     PC_IDLE,       1'b0};
            PC_BLEND_INIT: w = '{ACT_BLEND_INIT, COND_NEXT,     PC_IDLE,       1'b1};
            PC_BLEND_STEP: w = '{ACT_DIV_STEP,   COND_CNT_NZ,   PC_BLEND_STEP, 1'b0};
            PC_EMIT:       w = '{ACT_EMIT,       COND_OUT_BUSY, PC_EMIT,       1'b0};
            PC_RETURN:     w = '{ACT_NOP,        COND_ALWAYS,   PC_IDLE,       1'b0};
            default:       w = '{ACT_NOP,        COND_ALWAYS,   PC_IDLE,       1'b0};
         endcase
         return w;
      end
   endfunction

endpackage

[design/fsa_req_if.sv]
`timescale 1ns / 1ps
interface fsa_req_if;
   import fsa_pkg::*;

   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic signed [ELAPSED_WIDTH-1:0] elapsed;

   modport source (output valid, output operation, output elapsed, input ready);
   modport sink   (input valid, input operation, input elapsed, output ready);
endinterface

[design/fsa_rsp_if.sv]
`timescale 1ns / 1ps
interface fsa_rsp_if;
   import fsa_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STEP_LIM_WIDTH-1:0]  step_count;
   logic                       dropped;
   logic [BLEND_WIDTH-1:0]     blend_fraction;
   logic [COUNT_WIDTH-1:0]     drop_count;
   logic [DROP_TIME_WIDTH-1:0] dropped_time;
   logic [COUNT_WIDTH-1:0]     total_steps;

   modport source (output valid, output step_count, output dropped, output blend_fraction,
                   output drop_count, output dropped_time, output total_steps, input ready);
   modport sink   (input valid, input step_count, input dropped, input blend_fraction,
                   input drop_count, input dropped_time, input total_steps, output ready);
endinterface

[design/fsa_csr_if.sv]
`timescale 1ns / 1ps
interface fsa_csr_if;
   import fsa_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/fsa_seq.sv]
`timescale 1ns / 1ps
module fsa_seq (
   input  logic                clock,
   input  logic                reset,
   input  fsa_pkg::status_type status,
   output fsa_pkg::ctrl_type   ctrl
);
   import fsa_pkg::*;

   logic [PC_WIDTH-1:0]  pc_ff, pc_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   word_type             word;
   logic                 taken;
   logic                 cnt_nz;

   assign word   = fsa_rom(pc_ff);
   assign cnt_nz = (cnt_ff != '0);

   always_comb begin
      unique case (word.cond)
         COND_NEXT:     taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_REQ:   taken = !status.req_valid;
         COND_OP_CLEAR: taken = status.op_clear;
         COND_CNT_NZ:   taken = cnt_nz;
         COND_OUT_BUSY: taken = status.out_busy;
         default:       taken = 1'b1;
      endcase
   end

   always_comb begin
      pc_in = taken ? word.target : pc_ff + 1'b1;
      if (word.load_cnt) begin
         cnt_in = DIV_LAST;
      end else if (word.cond == COND_CNT_NZ && cnt_nz) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= PC_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign ctrl.action = word.action;
endmodule

[design/fixed_step_accumulator.sv]
`timescale 1ns / 1ps
// Channel  Direction  Transfer when        Payload
// req_ch   in         valid && ready       operation, elapsed (signed Q7.24)
// rsp_ch   out        valid && ready       step_count, dropped, blend_fraction, totals
// csr_ch   in         valid (ready high)   index, data
//
// One item at a time. An advance item runs two 16-step restoring divide loops on
// the shared divide step, a clear item only the second. The result register holds
// a finished result while the next item is accepted; the sequencer waits at its
// emit step only while that register is full and the sink is not ready. Reset
// restores the register defaults and clears the held remainder and all totals.
module fixed_step_accumulator (
   input logic      clock,
   input logic      reset,
   fsa_req_if.sink   req_ch,
   fsa_rsp_if.source rsp_ch,
   fsa_csr_if.sink   csr_ch
);
   import fsa_pkg::*;

   // Configuration
   logic [STEP_LEN_WIDTH-1:0] step_ff;
   logic [STEP_LIM_WIDTH-1:0] limit_ff;
   logic [STEP_LEN_WIDTH-1:0] csr_len;
   logic [STEP_LIM_WIDTH-1:0] csr_lim;

   // Architectural state
   logic [REM_WIDTH-1:0]       rem_ff;
   logic [DROP_TIME_WIDTH-1:0] disc_ff;
   logic [COUNT_WIDTH-1:0]     drops_ff;
   logic [COUNT_WIDTH-1:0]     total_ff;

   // Working registers
   logic                      op_ff;
   logic [ACC_WIDTH-1:0]      acc_ff;
   logic [REM_WIDTH-1:0]      p_ff;
   logic [QUO_WIDTH-1:0]      q_ff;
   logic [STEP_LIM_WIDTH-1:0] steps_ff;
   logic                      drop_ff;
   logic [PROD_WIDTH-1:0]     prod_ff;
   logic [ACC_WIDTH-1:0]      left_ff;

   // Result register
   logic                       rsp_valid_ff;
   logic [STEP_LIM_WIDTH-1:0]  out_steps_ff;
   logic                       out_drop_ff;
   logic [BLEND_WIDTH-1:0]     out_blend_ff;
   logic [COUNT_WIDTH-1:0]     out_drops_ff;
   logic [DROP_TIME_WIDTH-1:0] out_disc_ff;
   logic [COUNT_WIDTH-1:0]     out_total_ff;

   status_type status;
   ctrl_type   ctrl;

   logic                      req_xfer;
   logic                      out_busy;
   logic                      emit;
   logic [ACC_WIDTH-1:0]      add_in;
   logic [STEP_LEN_WIDTH-1:0] trial;
   logic [STEP_LEN_WIDTH:0]   diff;
   logic                      fits;
   logic [DROP_TIME_WIDTH:0]  disc_sum;

   fsa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign out_busy         = rsp_valid_ff && !rsp_ch.ready;
   assign status.req_valid = req_ch.valid;
   assign status.op_clear  = (op_ff == OP_CLEAR);
   assign status.out_busy  = out_busy;

   assign req_ch.ready = (ctrl.action == ACT_ACCEPT);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign emit         = (ctrl.action == ACT_EMIT) && !out_busy;

   // Add elapsed time only when it is strictly positive. The held remainder stays
   // below 2^24, so the sum cannot reach the 32-bit ceiling.
   assign add_in = (req_ch.elapsed > 0) ?
                   ACC_WIDTH'(req_ch.elapsed[ELAPSED_WIDTH-2:0]) : '0;

   // One restoring divide step: shift the next dividend bit into the partial
   // remainder, subtract the step length where it fits, shift the quotient bit in.
   assign trial = {p_ff, q_ff[QUO_WIDTH-1]};
   assign diff  = {1'b0, trial} - {1'b0, step_ff};
   assign fits  = !diff[STEP_LEN_WIDTH];

   assign disc_sum = {1'b0, disc_ff} + (DROP_TIME_WIDTH+1)'(left_ff);

   // Clamp configuration writes into their legal ranges
   always_comb begin
      csr_len = csr_ch.data[STEP_LEN_WIDTH-1:0];
      if (csr_len < STEP_LENGTH_MIN) begin
         csr_len = STEP_LENGTH_MIN;
      end else if (csr_len > STEP_LENGTH_MAX) begin
         csr_len = STEP_LENGTH_MAX;
      end
      csr_lim = csr_ch.data[STEP_LIM_WIDTH-1:0];
      if (csr_lim == '0) begin
         csr_lim = 8'd1;
      end else if (csr_lim > STEP_LIMIT_MAX) begin
         csr_lim = STEP_LIMIT_MAX;
      end
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_LENGTH_RESET;
         limit_ff <= STEP_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == REG_STEP_LENGTH) begin
            step_ff <= csr_len;
         end
         if (csr_ch.index == REG_STEP_LIMIT) begin
            limit_ff <= csr_lim;
         end
      end
   end

   // Architectural state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         disc_ff      <= '0;
         drops_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (ctrl.action)
            ACT_CLAMP: begin
               // Within the limit: the divide remainder becomes the new remainder
               if (q_ff <= QUO_WIDTH'(limit_ff)) begin
                  rem_ff <= p_ff;
               end
            end
            ACT_LEFTOVER: begin
               total_ff <= total_ff + COUNT_WIDTH'(steps_ff);
            end
            ACT_DROP: begin
               if (drop_ff) begin
                  rem_ff  <= '0;
                  disc_ff <= disc_sum[DROP_TIME_WIDTH] ? '1 :
                             disc_sum[DROP_TIME_WIDTH-1:0];
                  if (drops_ff != '1) begin
                     drops_ff <= drops_ff + 1'b1;
                  end
               end
            end
            ACT_CLEAR: begin
               rem_ff   <= '0;
               disc_ff  <= '0;
               drops_ff <= '0;
            end
            default: begin
            end
         endcase

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath working registers, driven by the control word
   always_ff @(posedge clock) begin
      unique case (ctrl.action)
         ACT_ACCEPT: begin
            if (req_xfer) begin
               op_ff  <= req_ch.operation;
               acc_ff <= ACC_WIDTH'(rem_ff) + add_in;
            end
         end
         ACT_DIV_INIT: begin
            // Upper half is below 2^16, so it already sits under any step length
            p_ff <= REM_WIDTH'(acc_ff[ACC_WIDTH-1:QUO_WIDTH]);
            q_ff <= acc_ff[QUO_WIDTH-1:0];
         end
         ACT_DIV_STEP: begin
            p_ff <= fits ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
            q_ff <= {q_ff[QUO_WIDTH-2:0], fits};
         end
         ACT_CLAMP: begin
            prod_ff <= PROD_WIDTH'(limit_ff) * PROD_WIDTH'(step_ff);
            if (q_ff > QUO_WIDTH'(limit_ff)) begin
               steps_ff <= limit_ff;
               drop_ff  <= 1'b1;
            end else begin
               steps_ff <= q_ff[STEP_LIM_WIDTH-1:0];
               drop_ff  <= 1'b0;
            end
         end
         ACT_LEFTOVER: begin
            // Limit times step never exceeds the accumulator when the limit bites
            left_ff <= acc_ff - prod_ff[ACC_WIDTH-1:0];
         end
         ACT_CLEAR: begin
            steps_ff <= '0;
            drop_ff  <= 1'b0;
         end
         ACT_BLEND_INIT: begin
            // Fraction is remainder * 2^16 / step: feed sixteen zero bits
            p_ff <= rem_ff;
            q_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   // Result register: hold while the sink stalls
   always_ff @(posedge clock) begin
      if (emit) begin
         out_steps_ff <= steps_ff;
         out_drop_ff  <= drop_ff;
         out_blend_ff <= BLEND_WIDTH'(q_ff);
         out_drops_ff <= drops_ff;
         out_disc_ff  <= disc_ff;
         out_total_ff <= total_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.step_count     = out_steps_ff;
   assign rsp_ch.dropped        = out_drop_ff;
   assign rsp_ch.blend_fraction = out_blend_ff;
   assign rsp_ch.drop_count     = out_drops_ff;
   assign rsp_ch.dropped_time   = out_disc_ff;
   assign rsp_ch.total_steps    = out_total_ff;

   // A dropped item always took exactly the step limit
   a_drop_at_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_drop_ff |-> out_steps_ff == limit_ff)
      else $error("dropped result without full step count");

   // A drop discards the whole leftover, leaving no fraction
   a_drop_no_blend : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_drop_ff |-> out_blend_ff == '0)
      else $error("dropped result carries a blend fraction");

   // The fraction comes from a 16-bit quotient, so it stays under one
   a_blend_below_one : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !out_blend_ff[BLEND_WIDTH-1])
      else $error("blend fraction reached one");

   // A stalled result is never overwritten by the next one
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      out_busy |-> !emit)
      else $error("result register loaded while full");
endmodule

[test/fsa_frame_checker.sv]
`timescale 1ns / 1ps
module fsa_frame_checker (
   input  logic clock,
   input  logic reset,
   fsa_req_if   req,
   fsa_rsp_if   rsp,
   fsa_csr_if   csr,
   output int   error_count,
   output int   pending
);
   import fsa_pkg::*;

   typedef struct packed {
      logic [STEP_LIM_WIDTH-1:0]  step_count;
      logic                       dropped;
      logic [BLEND_WIDTH-1:0]     blend_fraction;
      logic [COUNT_WIDTH-1:0]     drop_count;
      logic [DROP_TIME_WIDTH-1:0] dropped_time;
      logic [COUNT_WIDTH-1:0]     total_steps;
   } frame_report_type;

   localparam logic [63:0] ACC_CEILING  = 64'hFFFF_FFFF;
   localparam logic [63:0] LOST_CEILING = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] BLEND_ONE    = 64'd65536;

   // Shadow of the step registers and of the frame-time state.
   logic [STEP_LEN_WIDTH-1:0]  step_length;
   logic [STEP_LIM_WIDTH-1:0]  step_limit;
   logic [ACC_WIDTH-1:0]       leftover;
   logic [DROP_TIME_WIDTH-1:0] lost_time;
   logic [COUNT_WIDTH-1:0]     drop_events;
   logic [COUNT_WIDTH-1:0]     step_total;

   frame_report_type frame_reports[$];

   function automatic void apply_csr_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                                           input logic [CSR_DATA_WIDTH-1:0]  data);
      case (index)
         REG_STEP_LENGTH: begin
            if (data < STEP_LENGTH_MIN) step_length = STEP_LENGTH_MIN;
            else if (data > STEP_LENGTH_MAX) step_length = STEP_LENGTH_MAX;
            else step_length = data[STEP_LEN_WIDTH-1:0];
         end
         REG_STEP_LIMIT: begin
            if (data[STEP_LIM_WIDTH-1:0] == '0) step_limit = 8'd1;
            else if (data[STEP_LIM_WIDTH-1:0] > STEP_LIMIT_MAX) step_limit = STEP_LIMIT_MAX;
            else step_limit = data[STEP_LIM_WIDTH-1:0];
         end
         default: ;
      endcase
   endfunction

   // Advance the frame clock by one item and build the report it yields.
   function automatic frame_report_type accumulate_frame(input logic op,
                                                      input logic signed [ELAPSED_WIDTH-1:0] elapsed);
      frame_report_type r;
      logic [63:0]   acc;
      logic [63:0]   step;
      logic [63:0]   steps;
      logic [63:0]   lost;
      logic [63:0]   blend;
      r = '0;
      step = 64'(step_length);
      if (step < 64'(STEP_LENGTH_MIN)) step = 64'(STEP_LENGTH_MIN);
      if (op == OP_CLEAR) begin
         leftover    = '0;
         lost_time   = '0;
         drop_events = '0;
      end else begin
         acc = 64'(leftover);
         if (elapsed > 0) begin
            acc = acc + {32'b0, elapsed};
            if (acc > ACC_CEILING) acc = ACC_CEILING;
         end
         steps = acc / step;
         if (steps > 64'(step_limit)) steps = 64'(step_limit);
         acc = acc - steps * step;
         if (acc >= step) begin
            // past the catch-up ceiling: drop everything left
            r.dropped = 1'b1;
            lost = 64'(lost_time) + acc;
            if (lost > LOST_CEILING) lost = LOST_CEILING;
            lost_time = lost[DROP_TIME_WIDTH-1:0];
            if (drop_events != '1) drop_events = drop_events + 1'b1;
            acc = '0;
         end
         leftover     = acc[ACC_WIDTH-1:0];
         step_total   = step_total + steps[COUNT_WIDTH-1:0];
         r.step_count = steps[STEP_LIM_WIDTH-1:0];
      end
      blend = {leftover, 16'b0} / step;
      if (blend > BLEND_ONE) blend = BLEND_ONE;
      r.blend_fraction = blend[BLEND_WIDTH-1:0];
      r.drop_count     = drop_events;
      r.dropped_time   = lost_time;
      r.total_steps    = step_total;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      frame_report_type want;
      if (reset) begin
         step_length = STEP_LENGTH_RESET;
         step_limit  = STEP_LIMIT_RESET;
         leftover    = '0;
         lost_time   = '0;
         drop_events = '0;
         step_total  = '0;
         frame_reports.delete();
         pending     = 0;
         error_count = 0;
      end else begin
         // compare first so a result never meets the item accepted on the same edge
         if (rsp.valid && rsp.ready) begin
            if (frame_reports.size() == 0) begin
               $error("result transfer with no item outstanding");
               error_count++;
            end else begin
               want = frame_reports.pop_front();
               pending--;
               check_field("step_count", want.step_count, rsp.step_count);
               check_field("dropped", want.dropped, rsp.dropped);
               check_field("blend_fraction", want.blend_fraction, rsp.blend_fraction);
               check_field("drop_count", want.drop_count, rsp.drop_count);
               check_field("dropped_time", want.dropped_time, rsp.dropped_time);
               check_field("total_steps", want.total_steps, rsp.total_steps);
            end
         end
         if (csr.valid && csr.ready) apply_csr_write(csr.index, csr.data);
         if (req.valid && req.ready) begin
            frame_reports.push_back(accumulate_frame(req.operation, req.elapsed));
            pending++;
         end
      end
   end

endmodule

[test/fixed_step_accumulator_tb.sv]
`timescale 1ns / 1ps
module fixed_step_accumulator_tb;
   import fsa_pkg::*;

   localparam int     RESET_CYCLES   = 3;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     SETTLE_CYCLES  = 4;    // sequencer returns to idle through its return step after emit
   localparam int     TAIL_CYCLES    = 60;   // longer than one advance item
   localparam int     BLOCKS         = 12;
   localparam int     BLOCK_ITEMS    = 100;
   localparam int     STEADY_BLOCKS  = 2;    // closing blocks run without any idling
   localparam int     DEFAULT_STEP   = STEP_LENGTH_RESET;
   localparam longint ELAPSED_MAX    = 64'h7FFF_FFFF;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FIRST_UNMAPPED = REG_STEP_LIMIT + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LAST_UNMAPPED  = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_enable;
   int   shape_step;     // effective step length, used only to aim the stimulus
   int   shape_limit;    // effective step limit, same purpose
   int   error_count;
   int   pending;
   int   quiet_cycles = 0;

   fsa_req_if req ();
   fsa_rsp_if rsp ();
   fsa_csr_if csr ();

   fixed_step_accumulator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   fsa_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr         (csr),
      .error_count (error_count),
      .pending     (pending)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: end the run once no channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: hold ready low in random bursts while idling is on.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Present one frame item and hold it until the transfer. Valid stays high
   // afterwards so back-to-back items need no extra edge.
   task automatic send_frame(input logic op, input logic [ELAPSED_WIDTH-1:0] elapsed);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req.valid     <= 1'b1;
      req.operation <= op;
      req.elapsed   <= elapsed;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every outstanding result has come back.
   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register transfer; track the effective value for stimulus shaping.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0]  data);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= data;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      @(negedge clock);
      csr.valid <= 1'b0;
      case (index)
         REG_STEP_LENGTH:
            shape_step = (data < STEP_LENGTH_MIN) ? int'(STEP_LENGTH_MIN) :
                         (data > STEP_LENGTH_MAX) ? int'(STEP_LENGTH_MAX) : int'(data);
         REG_STEP_LIMIT:
            shape_limit = (data[STEP_LIM_WIDTH-1:0] == '0) ? 1 : int'(data[STEP_LIM_WIDTH-1:0]);
         default: ;
      endcase
   endtask

   // Mostly frame times that land around whole multiples of the step and up to a
   // bit past the catch-up ceiling; the rest is zero, negative or full-range noise.
   function automatic logic [ELAPSED_WIDTH-1:0] pick_elapsed();
      longint span;
      longint near;
      span = longint'(shape_step) * longint'(shape_limit + 2);
      if (span > ELAPSED_MAX) span = ELAPSED_MAX;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {1'b1, 31'($urandom)};
         2: return $urandom;
         3, 4: begin
            near = longint'(shape_step) * longint'($urandom_range(0, shape_limit + 1)) +
                   longint'($urandom_range(0, 16)) - 64'sd8;
            if (near > ELAPSED_MAX) near = ELAPSED_MAX;
            return near[ELAPSED_WIDTH-1:0];
         end
         default: return $urandom_range(0, 32'(span));
      endcase
   endfunction

   initial begin
      int   block;
      int   n;
      logic op;

      req.valid     = 1'b0;
      req.operation = OP_ADVANCE;
      req.elapsed   = '0;
      csr.valid     = 1'b0;
      csr.index     = REG_STEP_LENGTH;
      csr.data      = '0;
      idle_enable   = 1'b0;
      shape_step    = DEFAULT_STEP;
      shape_limit   = STEP_LIMIT_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: step 279620, at most 5 steps per item.
      send_frame(OP_ADVANCE, 32'd0);                      // nothing held, nothing added
      send_frame(OP_ADVANCE, 32'd1);                      // smallest positive time
      send_frame(OP_ADVANCE, 32'hFFFF_FFFF);              // minus one LSB, ignored
      send_frame(OP_ADVANCE, 32'h8000_0000);              // most negative, ignored
      send_frame(OP_ADVANCE, 32'(DEFAULT_STEP - 2));      // just short of a step
      send_frame(OP_ADVANCE, 32'd1);                      // completes exactly one step
      send_frame(OP_ADVANCE, 32'(5 * DEFAULT_STEP));      // right at the ceiling
      send_frame(OP_ADVANCE, 32'(6 * DEFAULT_STEP + 100)); // one step over: drop
      send_frame(OP_ADVANCE, 32'h7FFF_FFFF);              // largest frame time
      send_frame(OP_CLEAR, 32'h7FFF_FFFF);                // clear, time ignored
      send_frame(OP_ADVANCE, 32'(3 * DEFAULT_STEP + 7));
      drain();

      // Zero writes: step clamps up to its minimum, limit becomes one.
      write_csr(REG_STEP_LENGTH, '0);
      write_csr(REG_STEP_LIMIT, '0);
      write_csr(REG_FIRST_UNMAPPED, '1);                  // unmapped, ignored
      write_csr(REG_LAST_UNMAPPED, 25'd1);
      send_frame(OP_ADVANCE, 32'(3 * STEP_LENGTH_MIN));
      send_frame(OP_ADVANCE, 32'(STEP_LENGTH_MIN - 1));
      send_frame(OP_CLEAR, 32'd0);
      drain();

      // All-ones step clamps down to the maximum; widest step limit.
      write_csr(REG_STEP_LENGTH, '1);
      write_csr(REG_STEP_LIMIT, 25'(STEP_LIMIT_MAX));
      send_frame(OP_ADVANCE, 32'h7FFF_FFFF);              // leaves one LSB short of a step
      drain();

      // Shorten the step under a held remainder, then step it off with no time.
      write_csr(REG_STEP_LENGTH, 25'(STEP_LENGTH_MIN));
      send_frame(OP_ADVANCE, 32'd0);                      // full ceiling of steps
      send_frame(OP_ADVANCE, 32'h7FFF_FFFF);              // ceiling plus a drop
      send_frame(OP_ADVANCE, 32'h8000_0000);
      drain();

      // Off-by-one writes on both sides of the step range.
      write_csr(REG_STEP_LENGTH, 25'(STEP_LENGTH_MIN - 1));
      write_csr(REG_STEP_LENGTH, 25'(STEP_LENGTH_MAX + 1));
      write_csr(REG_STEP_LIMIT, 25'd1);
      send_frame(OP_ADVANCE, 32'(3 * STEP_LENGTH_MAX));

      // Random blocks. Every block starts from a full drain, so the sender
      // pauses for all results before it reconfigures.
      for (block = 0; block < BLOCKS; block++) begin
         drain();
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0:       write_csr(REG_STEP_LENGTH, STEP_LENGTH_MIN);
               1:       write_csr(REG_STEP_LENGTH, STEP_LENGTH_MAX);
               2:       write_csr(REG_STEP_LENGTH, 25'($urandom));
               default: write_csr(REG_STEP_LENGTH,
                                  25'($urandom_range(STEP_LENGTH_MIN, 4 * DEFAULT_STEP)));
            endcase
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0:       write_csr(REG_STEP_LIMIT, '0);
               1:       write_csr(REG_STEP_LIMIT, 25'(STEP_LIMIT_MAX));
               2:       write_csr(REG_STEP_LIMIT, 25'($urandom));
               default: write_csr(REG_STEP_LIMIT, 25'($urandom_range(1, 8)));
            endcase
         end
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_INDEX_WIDTH'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_UNMAPPED)),
                      25'($urandom));

         // some blocks run with no idling at all; the last ones never idle
         idle_enable = (block < BLOCKS - STEADY_BLOCKS) && ($urandom_range(0, 3) != 0);
         for (n = 0; n < BLOCK_ITEMS; n++) begin
            op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_ADVANCE;
            send_frame(op, pick_elapsed());
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
